FILE: src/tempo_synced_beat_repeat_unit_macros.svh
// assertion helpers for the beat-repeat unit checker
`ifndef TEMPO_SYNCED_BEAT_REPEAT_UNIT_MACROS_SVH
`define TEMPO_SYNCED_BEAT_REPEAT_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSBR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TSBR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/tsbr_pkg.sv
`timescale 1ns / 1ps

package tsbr_pkg;

	localparam logic [1:0] CMD_AUDIO = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_CLOCK = 2'd2;
	localparam logic [1:0] CMD_STOP  = 2'd3;

	localparam int unsigned SLICE_DIV [4] = '{4, 8, 16, 32};
	localparam int unsigned SEC_PER_MIN   = 60;
	localparam int unsigned BEATS_PER_BAR = 4;

	localparam logic [4:0] PULSES_PER_QUARTER = 5'd24;
	localparam logic [4:0] HALF_QUARTER       = 5'd12;
	localparam logic [2:0] NO_SLICE           = 3'd4;

	localparam int unsigned FIELD_W     = 24;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef logic signed [FIELD_W-1:0] sample_t;

	typedef struct packed {
		logic [1:0] cmd;
		sample_t    in_left;
		sample_t    in_right;
		logic       block_first;
		logic       repeat_on;
		logic [1:0] slice_sel;
	} in_item_t;

	typedef struct packed {
		sample_t     out_left;
		sample_t     out_right;
		logic        is_looping;
		logic [4:0]  pulse_now;
		logic        quarter_done;
		logic [31:0] quarter_samples;
	} out_item_t;

	// what the front hands the back for one item
	typedef struct packed {
		logic        is_audio;
		logic        is_replay;
		logic        read_ok;
		sample_t     raw_left;
		sample_t     raw_right;
		logic [4:0]  pulse_now;
		logic        quarter_done;
		logic [31:0] quarter_samples;
	} ctl_t;

endpackage

FILE: src/tsbr_front.sv
`timescale 1ns / 1ps

module tsbr_front #(
	parameter int unsigned STORE_DEPTH = 65536,
	parameter int unsigned SAMPLE_RATE = 48000,
	parameter int unsigned TEMPO_BPM   = 200,
	parameter int unsigned AW          = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tsbr_pkg::in_item_t  in_data,
	output logic                push_valid,
	input  logic                push_ready,
	output tsbr_pkg::ctl_t      push_ctl,
	output logic [AW-1:0]       push_addr
);

	localparam int unsigned LW = $clog2(STORE_DEPTH + 1);
	localparam int unsigned PW = AW + 1;

	localparam longint unsigned NUM = longint'(SAMPLE_RATE) * tsbr_pkg::SEC_PER_MIN *
		tsbr_pkg::BEATS_PER_BAR;
	localparam longint unsigned RAW0 = NUM / (longint'(TEMPO_BPM) * tsbr_pkg::SLICE_DIV[0]);
	localparam longint unsigned RAW1 = NUM / (longint'(TEMPO_BPM) * tsbr_pkg::SLICE_DIV[1]);
	localparam longint unsigned RAW2 = NUM / (longint'(TEMPO_BPM) * tsbr_pkg::SLICE_DIV[2]);
	localparam longint unsigned RAW3 = NUM / (longint'(TEMPO_BPM) * tsbr_pkg::SLICE_DIV[3]);
	localparam longint unsigned DEPTH_L = longint'(STORE_DEPTH);
	localparam logic [LW-1:0] LOOP_LEN [4] = '{
		LW'(RAW0 > DEPTH_L ? DEPTH_L : RAW0),
		LW'(RAW1 > DEPTH_L ? DEPTH_L : RAW1),
		LW'(RAW2 > DEPTH_L ? DEPTH_L : RAW2),
		LW'(RAW3 > DEPTH_L ? DEPTH_L : RAW3)
	};
	localparam logic [PW-1:0] DEPTH_P = PW'(STORE_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(STORE_DEPTH - 1);

	logic [AW-1:0] wr_idx_q, wr_idx_d;
	logic          filled_q, filled_d;
	logic [AW-1:0] loop_start_q, loop_start_d;
	logic [LW-1:0] loop_off_q, loop_off_d;
	logic [LW-1:0] loop_len_q, loop_len_d;
	logic [2:0]    act_slice_q, act_slice_d;
	logic          was_rep_q, was_rep_d;
	logic          blk_rep_q, blk_rep_d;
	logic          running_q, running_d;
	logic [4:0]    pulse_q, pulse_d;
	logic [31:0]   samp_cnt_q, samp_cnt_d;
	logic [31:0]   last_qtr_q, last_qtr_d;

	logic          take;
	logic [LW-1:0] new_len;
	logic [PW-1:0] wi_x, len_x, start_x;
	logic [PW-1:0] pos_x;
	logic [AW-1:0] pos;
	logic [LW-1:0] off_inc;
	logic [4:0]    pulse_inc;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign take       = in_valid && push_ready;

	// loop start for a fresh slice: that many entries behind the write index
	assign new_len = LOOP_LEN[in_data.slice_sel];
	assign wi_x    = PW'(wr_idx_q);
	assign len_x   = PW'(new_len);
	assign start_x = (wi_x >= len_x) ? (wi_x - len_x) : (DEPTH_P + wi_x - len_x);
	assign pulse_inc = pulse_q + 5'd1;

	always_comb begin
		wr_idx_d     = wr_idx_q;
		filled_d     = filled_q;
		loop_start_d = loop_start_q;
		loop_off_d   = loop_off_q;
		loop_len_d   = loop_len_q;
		act_slice_d  = act_slice_q;
		was_rep_d    = was_rep_q;
		blk_rep_d    = blk_rep_q;
		running_d    = running_q;
		pulse_d      = pulse_q;
		samp_cnt_d   = samp_cnt_q;
		last_qtr_d   = last_qtr_q;
		pos_x        = '0;
		pos          = '0;
		off_inc      = '0;
		push_ctl     = '0;
		push_addr    = '0;
		unique case (in_data.cmd)
			tsbr_pkg::CMD_AUDIO: begin
				if (in_data.block_first) begin
					if (in_data.repeat_on &&
					    (!was_rep_q || {1'b0, in_data.slice_sel} != act_slice_q) &&
					    (pulse_q == 5'd0 || pulse_q == tsbr_pkg::HALF_QUARTER)) begin
						act_slice_d  = {1'b0, in_data.slice_sel};
						loop_len_d   = new_len;
						loop_start_d = start_x[AW-1:0];
						loop_off_d   = '0;
					end
					was_rep_d = in_data.repeat_on;
					blk_rep_d = in_data.repeat_on;
				end
				push_ctl.is_audio  = 1'b1;
				push_ctl.raw_left  = in_data.in_left;
				push_ctl.raw_right = in_data.in_right;
				if (blk_rep_d) begin
					pos_x = PW'(loop_start_d) + PW'(loop_off_d);
					if (pos_x >= DEPTH_P) begin
						pos_x = pos_x - DEPTH_P;
					end
					pos = pos_x[AW-1:0];
					push_ctl.is_replay = 1'b1;
					// entries past the fill point are not written yet; read_ok marks them so their result is zero
					push_ctl.read_ok   = filled_q || (pos < wr_idx_q);
					push_addr          = pos;
					off_inc = loop_off_d + 1'b1;
					loop_off_d = (off_inc >= loop_len_d) ? '0 : off_inc;
				end else begin
					push_addr = wr_idx_q;
					if (wr_idx_q == LAST_IDX) begin
						wr_idx_d = '0;
						filled_d = 1'b1;
					end else begin
						wr_idx_d = wr_idx_q + 1'b1;
					end
				end
				samp_cnt_d = samp_cnt_q + 32'd1;
			end
			tsbr_pkg::CMD_START: begin
				running_d  = 1'b1;
				pulse_d    = '0;
				samp_cnt_d = '0;
			end
			tsbr_pkg::CMD_CLOCK: begin
				if (running_q) begin
					if (pulse_inc >= tsbr_pkg::PULSES_PER_QUARTER) begin
						pulse_d               = '0;
						last_qtr_d            = samp_cnt_q;
						samp_cnt_d            = '0;
						push_ctl.quarter_done = 1'b1;
					end else begin
						pulse_d = pulse_inc;
					end
				end
			end
			tsbr_pkg::CMD_STOP: begin
				running_d = 1'b0;
			end
			default: begin
				running_d = running_q;
			end
		endcase
		push_ctl.pulse_now       = pulse_d;
		push_ctl.quarter_samples = last_qtr_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q     <= '0;
			filled_q     <= 1'b0;
			loop_start_q <= '0;
			loop_off_q   <= '0;
			loop_len_q   <= '0;
			act_slice_q  <= tsbr_pkg::NO_SLICE;
			was_rep_q    <= 1'b0;
			blk_rep_q    <= 1'b0;
			running_q    <= 1'b0;
			pulse_q      <= '0;
			samp_cnt_q   <= '0;
			last_qtr_q   <= '0;
		end else if (take) begin
			wr_idx_q     <= wr_idx_d;
			filled_q     <= filled_d;
			loop_start_q <= loop_start_d;
			loop_off_q   <= loop_off_d;
			loop_len_q   <= loop_len_d;
			act_slice_q  <= act_slice_d;
			was_rep_q    <= was_rep_d;
			blk_rep_q    <= blk_rep_d;
			running_q    <= running_d;
			pulse_q      <= pulse_d;
			samp_cnt_q   <= samp_cnt_d;
			last_qtr_q   <= last_qtr_d;
		end
	end

endmodule

FILE: src/tsbr_queue.sv
`timescale 1ns / 1ps

module tsbr_queue #(
	parameter int unsigned AW = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  tsbr_pkg::ctl_t  push_ctl,
	input  logic [AW-1:0]   push_addr,
	output logic            pop_valid,
	input  logic            pop_ready,
	output tsbr_pkg::ctl_t  pop_ctl,
	output logic [AW-1:0]   pop_addr
);

	localparam int unsigned PTR_W = $clog2(tsbr_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(tsbr_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(tsbr_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(tsbr_pkg::QUEUE_DEPTH);

	tsbr_pkg::ctl_t ctl_q  [tsbr_pkg::QUEUE_DEPTH];
	logic [AW-1:0]  addr_q [tsbr_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign push_ready = (cnt_q != FULL_CNT);
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_ctl    = ctl_q[rd_ptr_q];
	assign pop_addr   = addr_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ctl_q[wr_ptr_q]  <= push_ctl;
			addr_q[wr_ptr_q] <= push_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/tsbr_back.sv
`timescale 1ns / 1ps

module tsbr_back #(
	parameter int unsigned STORE_DEPTH  = 65536,
	parameter int unsigned SAMPLE_WIDTH = 24,
	parameter int unsigned AW           = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  tsbr_pkg::ctl_t      pop_ctl,
	input  logic [AW-1:0]       pop_addr,
	output logic                out_valid,
	input  logic                out_ready,
	output tsbr_pkg::out_item_t out_data
);

	localparam int unsigned SW = SAMPLE_WIDTH;

	logic [2*SW-1:0] mem [STORE_DEPTH];
	logic [2*SW-1:0] rd_q;

	logic           valid_s1;
	tsbr_pkg::ctl_t ctl_s1;
	logic           out_valid_q;
	tsbr_pkg::out_item_t out_q, fmt;

	logic adv, pop;
	logic signed [SW-1:0] wr_l, wr_r, rd_l, rd_r;

	assign adv       = !out_valid_q || out_ready;
	assign pop       = pop_valid && (!valid_s1 || adv);
	assign pop_ready = !valid_s1 || adv;

	assign wr_l = SW'(pop_ctl.raw_left);
	assign wr_r = SW'(pop_ctl.raw_right);
	assign rd_l = rd_q[SW-1:0];
	assign rd_r = rd_q[2*SW-1:SW];

	// one store access per audio item: write on pass-through, read on replay
	always_ff @(posedge clk) begin
		if (pop && pop_ctl.is_audio && !pop_ctl.is_replay) begin
			mem[pop_addr] <= {wr_r, wr_l};
		end
		if (pop && pop_ctl.is_replay) begin
			rd_q <= mem[pop_addr];
		end
		if (pop) begin
			ctl_s1 <= pop_ctl;
		end
		if (valid_s1 && adv) begin
			out_q <= fmt;
		end
	end

	always_comb begin
		fmt                 = '0;
		fmt.pulse_now       = ctl_s1.pulse_now;
		fmt.quarter_done    = ctl_s1.quarter_done;
		fmt.quarter_samples = ctl_s1.quarter_samples;
		if (ctl_s1.is_replay) begin
			fmt.is_looping = 1'b1;
			if (ctl_s1.read_ok) begin
				fmt.out_left  = tsbr_pkg::sample_t'(rd_l);
				fmt.out_right = tsbr_pkg::sample_t'(rd_r);
			end
		end else if (ctl_s1.is_audio) begin
			fmt.out_left  = ctl_s1.raw_left;
			fmt.out_right = ctl_s1.raw_right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: src/tempo_synced_beat_repeat_unit.sv
`timescale 1ns / 1ps

// Stereo beat-repeat unit. Each input item (an audio sample pair or a MIDI start, clock or
// stop event) yields exactly one result item, in order. The unit takes one item per cycle
// when the output side keeps up. An accepted item is first written into the queue; the
// store is read or written as the item leaves the queue, and the output register then
// loads the formatted result and holds it while out_ready is low. The sample store is
// read or written once per audio item. A two-entry queue between the decode front and the
// store back lets either side stall on its own. While repeating,
// the unit replays the last tempo-derived slice (a quarter down to a thirty-second of a
// bar at TEMPO_BPM) of the store; a loop starts or changes slice only at a block's first
// sample and only on pulse 0 or 12 of the 24-pulse MIDI clock. Store entries not yet
// written since reset read as zero; no clearing pass is needed after reset.
module tempo_synced_beat_repeat_unit #(
	parameter int unsigned STORE_DEPTH  = 65536,
	parameter int unsigned SAMPLE_RATE  = 48000,
	parameter int unsigned TEMPO_BPM    = 200,
	parameter int unsigned SAMPLE_WIDTH = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tsbr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tsbr_pkg::out_item_t out_data
);

	localparam int unsigned AW = $clog2(STORE_DEPTH);

	logic           push_valid, push_ready, pop_valid, pop_ready;
	tsbr_pkg::ctl_t push_ctl, pop_ctl;
	logic [AW-1:0]  push_addr, pop_addr;

	tsbr_front #(
		.STORE_DEPTH(STORE_DEPTH),
		.SAMPLE_RATE(SAMPLE_RATE),
		.TEMPO_BPM  (TEMPO_BPM),
		.AW         (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_ctl  (push_ctl),
		.push_addr (push_addr)
	);

	tsbr_queue #(
		.AW(AW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_ctl  (push_ctl),
		.push_addr (push_addr),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_ctl   (pop_ctl),
		.pop_addr  (pop_addr)
	);

	tsbr_back #(
		.STORE_DEPTH (STORE_DEPTH),
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.AW          (AW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_ctl  (pop_ctl),
		.pop_addr (pop_addr),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

FILE: src/tsbr_checker.sv
`timescale 1ns / 1ps

`include "tempo_synced_beat_repeat_unit_macros.svh"

module tsbr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input tsbr_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input tsbr_pkg::out_item_t out_data
);

	// a held result keeps its payload
	`TSBR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")

	// a quarter completes only on a clock event, which wraps the pulse count
	`TSBR_ASSERT_NOW(a_qdone_wrap, out_valid && out_data.quarter_done, out_data.pulse_now == 5'd0 && !out_data.is_looping, "quarter done without pulse wrap")

	// pulse count never reaches a full quarter
	`TSBR_ASSERT_NOW(a_pulse_range, out_valid, out_data.pulse_now < tsbr_pkg::PULSES_PER_QUARTER, "pulse count out of range")

	// the quarter length only changes on a result that completes a quarter
	`TSBR_ASSERT_NEXT(a_qsamp_change, out_valid && out_ready, !out_valid || out_data.quarter_done || out_data.quarter_samples == $past(out_data.quarter_samples), "quarter length changed without quarter done")

endmodule

bind tempo_synced_beat_repeat_unit tsbr_checker u_tsbr_checker (.*);
